@@ src/rtc_pkg.sv @@
// ----------------------------------------------------------------------------
// rtc_pkg: shared types and constants of the real-time clock
// Operation codes, register offsets, config indexes and the bus byte order.
// ----------------------------------------------------------------------------
`default_nettype none

package rtc_pkg;

  // Operation codes of an input word
  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2
  } rtc_op_t;

  // Register window offsets
  localparam logic [31:0] OFS_TIME_LOW   = 32'h0000_0000;
  localparam logic [31:0] OFS_TIME_HIGH  = 32'h0000_0004;
  localparam logic [31:0] OFS_ALARM_LOW  = 32'h0000_0008;
  localparam logic [31:0] OFS_ALARM_HIGH = 32'h0000_000c;
  localparam logic [31:0] OFS_CLEAR_IRQ  = 32'h0000_0010;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NS_PER_TICK  = 4'd1;

  localparam logic [29:0] NS_PER_TICK_RESET = 30'd1_000_000_000;

  // Byte order of the bus: set for a big-endian bus
  localparam logic BIG_ENDIAN_BUS = 1'b0;

  // One input word in the first stage
  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] bus_address;
    logic [31:0] write_data;
  } rtc_word_t;

  // One result word
  typedef struct packed {
    logic [31:0] read_data;
    logic        bad_offset;
    logic        irq_level;
  } rtc_result_t;

  // Configuration write strobe and payload
  typedef struct packed {
    logic                 we;
    logic [CFG_IDX_W-1:0] index;
    logic [31:0]          data;
  } rtc_cfg_wr_t;

  function automatic logic [31:0] bus_order(input logic [31:0] v);
    if (BIG_ENDIAN_BUS) begin
      return {v[7:0], v[15:8], v[23:16], v[31:24]};
    end
    return v;
  endfunction

endpackage

`default_nettype wire

@@ src/rtc_core.sv @@
// ----------------------------------------------------------------------------
// rtc_core: clock state and per-word update
// Holds counter, latch, alarm and interrupt state; computes the result of the
// word in the first stage and commits the state when that word moves on.
// ----------------------------------------------------------------------------
`default_nettype none

module rtc_core
  import rtc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire rtc_cfg_wr_t cfg_wr,
  input  wire logic        fire,
  input  wire rtc_word_t   word,
  output rtc_result_t      result
);

  logic [31:0] base_r,       base_nxt;
  logic [29:0] step_r,       step_nxt;
  logic [63:0] time_r,       time_nxt;
  logic [63:0] latched_r,    latched_nxt;
  logic [31:0] alarm_lo_r,   alarm_lo_nxt;
  logic [31:0] alarm_hi_r,   alarm_hi_nxt;
  logic        armed_r,      armed_nxt;
  logic        irq_r,        irq_nxt;

  logic [31:0] offset;
  logic [31:0] wdata;
  logic [63:0] time_sum;
  logic [31:0] rdata;
  logic        bad;

  assign offset   = word.bus_address - base_r;
  assign wdata    = bus_order(word.write_data);
  assign time_sum = time_r + {34'd0, step_r};

  always_comb begin
    base_nxt     = base_r;
    step_nxt     = step_r;
    time_nxt     = time_r;
    latched_nxt  = latched_r;
    alarm_lo_nxt = alarm_lo_r;
    alarm_hi_nxt = alarm_hi_r;
    armed_nxt    = armed_r;
    irq_nxt      = irq_r;
    rdata        = 32'd0;
    bad          = 1'b0;

    unique case (rtc_op_t'(word.operation))
      OP_READ: begin
        case (offset)
          OFS_TIME_LOW: begin
            latched_nxt = time_r;
            rdata       = bus_order(time_r[31:0]);
          end
          OFS_TIME_HIGH: rdata = bus_order(latched_r[63:32]);
          default:       bad   = 1'b1;
        endcase
      end
      OP_WRITE: begin
        case (offset)
          OFS_ALARM_LOW: begin
            alarm_lo_nxt = wdata;
            armed_nxt    = 1'b1;
          end
          OFS_ALARM_HIGH: alarm_hi_nxt = wdata;
          OFS_CLEAR_IRQ:  irq_nxt      = 1'b0;
          default:        bad          = 1'b1;
        endcase
      end
      OP_TICK: begin
        time_nxt = time_sum;
        if (armed_r && (time_sum >= {alarm_hi_r, alarm_lo_r})) begin
          irq_nxt   = 1'b1;
          armed_nxt = 1'b0;
        end
      end
      default: ;
    endcase

    // Config writes must arrive only while no word is in flight; the core does not enforce it
    if (cfg_wr.we) begin
      unique case (cfg_wr.index)
        CFG_BASE_ADDRESS: base_nxt = cfg_wr.data;
        CFG_NS_PER_TICK:  step_nxt = cfg_wr.data[29:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r     <= 32'd0;
      step_r     <= NS_PER_TICK_RESET;
      time_r     <= 64'd0;
      latched_r  <= 64'd0;
      alarm_lo_r <= 32'd0;
      alarm_hi_r <= 32'd0;
      armed_r    <= 1'b0;
      irq_r      <= 1'b0;
    end else begin
      base_r <= base_nxt;
      step_r <= step_nxt;
      if (fire) begin
        time_r     <= time_nxt;
        latched_r  <= latched_nxt;
        alarm_lo_r <= alarm_lo_nxt;
        alarm_hi_r <= alarm_hi_nxt;
        armed_r    <= armed_nxt;
        irq_r      <= irq_nxt;
      end
    end
  end

  assign result.read_data  = rdata;
  assign result.bad_offset = bad;
  assign result.irq_level  = irq_nxt;

endmodule

`default_nettype wire

@@ src/rtc_counter_with_alarm.sv @@
// ----------------------------------------------------------------------------
// rtc_counter_with_alarm: 64-bit nanosecond clock with alarm interrupt
// Register window of reads, writes and time ticks behind a valid/ready pair.
// ----------------------------------------------------------------------------
// Path: each word passes the input stage, then the result register; it waits
//   longer only while the result side stalls.
// Throughput: one word per cycle while the result side takes results; the 64-bit
//   add and compare of a tick sits between the input stage and the result register.
// Reset: synchronous, active low; clears counter, latch, alarm and interrupt,
//   sets the tick step to one second; no clearing pass.
`default_nettype none

module rtc_counter_with_alarm
  import rtc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // input words
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [1:0]           in_operation,
  input  wire logic [31:0]          in_bus_address,
  input  wire logic [31:0]          in_write_data,
  // result words
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [31:0]               out_read_data,
  output logic                      out_bad_offset,
  output logic                      out_irq_level,
  // configuration writes
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data
);

  logic        s1_valid_r;
  rtc_word_t   s1_word_r;
  logic        out_valid_r;
  rtc_result_t out_res_r;

  logic        out_free;
  logic        s1_adv;
  rtc_result_t core_res;
  rtc_cfg_wr_t cfg_wr;

  // Result register is free when empty or being taken this cycle
  assign out_free = !out_valid_r || out_ready;
  // Commit the staged word when its result can move into the output register
  assign s1_adv   = s1_valid_r && out_free;
  // Take a new word whenever the input stage empties or moves on
  assign in_ready = !s1_valid_r || s1_adv;

  // Config is to be written only while idle; the block leaves that to the user, so always accept it
  assign cfg_ready    = 1'b1;
  assign cfg_wr.we    = cfg_valid;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  // Hold the payload unless a new word is taken
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_word_r.operation   <= in_operation;
      s1_word_r.bus_address <= in_bus_address;
      s1_word_r.write_data  <= in_write_data;
    end
  end

  rtc_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_wr (cfg_wr),
    .fire   (s1_adv),
    .word   (s1_word_r),
    .result (core_res)
  );

  // Result register: drop valid once taken, load a new result on advance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res_r <= core_res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_data  = out_res_r.read_data;
  assign out_bad_offset = out_res_r.bad_offset;
  assign out_irq_level  = out_res_r.irq_level;

endmodule

`default_nettype wire

@@ src/rtc_checker.sv @@
// ----------------------------------------------------------------------------
// rtc_checker: port-level checks of the real-time clock
// Watches reset, latency, result hold and bad-offset read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rtc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_read_data,
  input wire logic        out_bad_offset,
  input wire logic        out_irq_level
);

  // No result straight after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // An accepted word is followed by a valid result behind the input stage and result register
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> ##1 out_valid)
    else $error("result missing two cycles after accept");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_read_data) &&
      $stable(out_bad_offset) && $stable(out_irq_level)))
    else $error("stalled result changed");

  // A bad access returns no data
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_bad_offset) |-> (out_read_data == 32'd0))
    else $error("bad offset with nonzero read data");

endmodule

bind rtc_counter_with_alarm rtc_checker u_rtc_checker (.*);

`default_nettype wire
